// ===== hw/rtl/ppi_pkg.sv =====
// planar pose integrator: shared constants, tables, state and command types
// no dependencies; used by ppi_cordic, ppi_datapath, ppi_ctrl and the top level
package ppi_pkg;

   localparam int ANGLE_BITS   = 16;   // fraction bits of cosine and sine
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_COUNT   = 24;
   localparam int STEPS        = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
   localparam int STEP_W       = $clog2(STEPS);
   localparam int ATAN_IDX_W   = $clog2(ATAN_COUNT);

   // field widths
   localparam int VEL_W  = 16;
   localparam int DT_W   = 16;
   localparam int POS_W  = 32;
   localparam int HEAD_W = 16;

   // datapath widths
   localparam int CS_W    = ANGLE_BITS + 3;       // cordic x and y, signed
   localparam int Z_W     = 33;                   // residual angle, 2^32 per turn
   localparam int PROD1_W = VEL_W + CS_W;         // velocity times cos or sin
   localparam int WV_W    = PROD1_W + 1;          // world velocity
   localparam int DTS_W   = DT_W + 1;             // time step as a signed operand
   localparam int PROD2_W = WV_W + DTS_W;         // world velocity times time step
   localparam int TURN1_W = 32;                   // turn rate times time step
   localparam int TURN2_W = 64;                   // scaled to binary angle
   localparam int SUM_W   = POS_W + 2;

   localparam int POS_SHIFT  = 12 + ANGLE_BITS;
   localparam int TURN_SHIFT = 44;

   localparam longint GAIN_Q24   = 10188014;
   localparam longint GAIN_START =
      ((GAIN_Q24 <<< 1) + (64'sd1 <<< (24 - ANGLE_BITS))) >>> (25 - ANGLE_BITS);
   localparam logic signed [CS_W-1:0] GAIN_INIT = CS_W'(GAIN_START);

   localparam logic signed [31:0] TURN_SCALE = 32'sd683565276;   // 2^32 / 2pi

   localparam logic signed [Z_W-1:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [Z_W-1:0] HALF_TURN    = 33'sd2147483648;

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

   // arctangent of 2^-i, 2^32 per turn, rounded to nearest
   localparam logic signed [31:0] ATAN_TABLE [ATAN_COUNT] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_PROJECT,
      ST_COMBINE,
      ST_SCALE,
      ST_COMMIT
   } ppi_state_type;

   typedef struct packed {
      logic              load;
      logic              rotate;
      logic              project;
      logic              combine;
      logic              scale;
      logic              commit;
      logic [STEP_W-1:0] step;
   } ppi_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } ppi_status_type;

endpackage

// ===== hw/rtl/ppi_cordic.sv =====
// rotation-mode cordic, one micro-rotation per step command
// depends on ppi_pkg for widths, start gain and the arctangent table
module ppi_cordic (
   input  logic                                 clock,
   input  logic                                 start,
   input  logic                                 step_en,
   input  logic [ppi_pkg::STEP_W-1:0]           step,
   input  logic [ppi_pkg::HEAD_W-1:0]           head,
   output logic signed [ppi_pkg::CS_W-1:0]      cos_out,
   output logic signed [ppi_pkg::CS_W-1:0]      sin_out
);

   logic signed [ppi_pkg::CS_W-1:0] x_ff, x_in;
   logic signed [ppi_pkg::CS_W-1:0] y_ff, y_in;
   logic signed [ppi_pkg::Z_W-1:0]  z_ff, z_in;
   logic                            flip_ff, flip_in;

   always_comb begin
      logic signed [ppi_pkg::Z_W-1:0] z0;
      logic signed [ppi_pkg::Z_W-1:0] atan;
      z0   = $signed({head[ppi_pkg::HEAD_W-1], head, 16'b0});
      atan = ppi_pkg::Z_W'(ppi_pkg::ATAN_TABLE[ppi_pkg::ATAN_IDX_W'(step)]);
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      if (start) begin
         // fold into the right half plane, negate the result later
         x_in    = ppi_pkg::GAIN_INIT;
         y_in    = '0;
         flip_in = 1'b0;
         z_in    = z0;
         if (z0 > ppi_pkg::QUARTER_TURN) begin
            z_in    = z0 - ppi_pkg::HALF_TURN;
            flip_in = 1'b1;
         end else if (z0 < -ppi_pkg::QUARTER_TURN) begin
            z_in    = z0 + ppi_pkg::HALF_TURN;
            flip_in = 1'b1;
         end
      end else if (step_en) begin
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> step);
            y_in = y_ff + (x_ff >>> step);
            z_in = z_ff - atan;
         end else begin
            x_in = x_ff + (y_ff >>> step);
            y_in = y_ff - (x_ff >>> step);
            z_in = z_ff + atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// ===== hw/rtl/ppi_datapath.sv =====
// pose datapath: operand capture, cordic, products, pose registers, result register
// depends on ppi_pkg and ppi_cordic; sequenced by ppi_ctrl through ppi_cmd_type
module ppi_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ppi_pkg::ppi_cmd_type                   cmd,
   output ppi_pkg::ppi_status_type                status,
   input  logic [63:0]                            req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [79:0]                            rsp_tdata
);

   // captured word
   logic signed [ppi_pkg::VEL_W-1:0]   vx_ff, vy_ff, wz_ff;
   logic signed [ppi_pkg::DTS_W-1:0]   dt_ff;

   // products
   logic signed [ppi_pkg::PROD1_W-1:0] xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [ppi_pkg::WV_W-1:0]    wx_ff, wy_ff;
   logic signed [ppi_pkg::PROD2_W-1:0] px_ff, py_ff;
   logic signed [ppi_pkg::TURN1_W-1:0] t1_ff;
   logic signed [ppi_pkg::TURN2_W-1:0] t2_ff;
   logic [ppi_pkg::HEAD_W-1:0]         dturn_ff;

   // pose state and result register
   logic signed [ppi_pkg::POS_W-1:0]   pos_x_ff, pos_x_in;
   logic signed [ppi_pkg::POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [ppi_pkg::HEAD_W-1:0]         yaw_ff, yaw_in;
   logic [79:0]                        out_ff;
   logic                               out_valid_ff, out_valid_in;

   logic signed [ppi_pkg::CS_W-1:0]    cos_val, sin_val;
   logic signed [ppi_pkg::TURN2_W-1:0] t2_round;

   ppi_cordic u_cordic (
      .clock   (clock),
      .start   (cmd.load),
      .step_en (cmd.rotate),
      .step    (cmd.step),
      .head    (yaw_ff),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   function automatic logic signed [ppi_pkg::POS_W-1:0] pos_add(
      input logic signed [ppi_pkg::POS_W-1:0]   pos,
      input logic signed [ppi_pkg::PROD2_W-1:0] prod
   );
      logic signed [ppi_pkg::PROD2_W-1:0] rounded;
      logic signed [ppi_pkg::SUM_W-1:0]   sum;
      rounded = (prod + (ppi_pkg::PROD2_W'(1) <<< (ppi_pkg::POS_SHIFT - 1)))
                >>> ppi_pkg::POS_SHIFT;
      sum = ppi_pkg::SUM_W'(pos) + ppi_pkg::SUM_W'(rounded);
      if (sum > ppi_pkg::SUM_W'(ppi_pkg::POS_MAX))
         return ppi_pkg::POS_MAX;
      else if (sum < ppi_pkg::SUM_W'(ppi_pkg::POS_MIN))
         return ppi_pkg::POS_MIN;
      else
         return sum[ppi_pkg::POS_W-1:0];
   endfunction

   assign t2_round = t2_ff + (ppi_pkg::TURN2_W'(1) <<< (ppi_pkg::TURN_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff <= $signed(req_tdata[15:0]);
         vy_ff <= $signed(req_tdata[31:16]);
         wz_ff <= $signed(req_tdata[47:32]);
         dt_ff <= $signed({1'b0, req_tdata[63:48]});
      end
      if (cmd.project) begin
         xc_ff <= vx_ff * cos_val;
         ys_ff <= vy_ff * sin_val;
         xs_ff <= vx_ff * sin_val;
         yc_ff <= vy_ff * cos_val;
         t1_ff <= ppi_pkg::TURN1_W'(wz_ff * dt_ff);
      end
      if (cmd.combine) begin
         wx_ff <= ppi_pkg::WV_W'(xc_ff) - ppi_pkg::WV_W'(ys_ff);
         wy_ff <= ppi_pkg::WV_W'(xs_ff) + ppi_pkg::WV_W'(yc_ff);
         t2_ff <= t1_ff * ppi_pkg::TURN_SCALE;
      end
      if (cmd.scale) begin
         px_ff    <= wx_ff * dt_ff;
         py_ff    <= wy_ff * dt_ff;
         // only the low bits of the shifted change survive the wrap
         dturn_ff <= t2_round[ppi_pkg::TURN_SHIFT +: ppi_pkg::HEAD_W];
      end
      if (cmd.commit)
         out_ff <= {yaw_in, pos_y_in, pos_x_in};
   end

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      yaw_in       = yaw_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready)
         out_valid_in = 1'b0;
      if (cmd.commit) begin
         pos_x_in     = pos_add(pos_x_ff, px_ff);
         pos_y_in     = pos_add(pos_y_ff, py_ff);
         yaw_in       = yaw_ff + dturn_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         yaw_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         yaw_ff       <= yaw_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.out_blocked = out_valid_ff && !rsp_tready;
   assign rsp_tvalid         = out_valid_ff;
   assign rsp_tdata          = out_ff;

endmodule

// ===== hw/rtl/ppi_ctrl.sv =====
// sequencer for the pose integrator: accept, cordic steps, product stages, commit
// depends on ppi_pkg for the state enum and the command and status structs
module ppi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ppi_pkg::ppi_status_type status,
   output ppi_pkg::ppi_cmd_type    cmd
);

   ppi_pkg::ppi_state_type          state_ff, state_in;
   logic [ppi_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            last_step;

   assign last_step = (step_ff == ppi_pkg::STEP_W'(ppi_pkg::STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppi_pkg::ST_IDLE: begin
            if (req_tvalid)
               state_in = ppi_pkg::ST_ROTATE;
         end
         ppi_pkg::ST_ROTATE: begin
            if (last_step)
               state_in = ppi_pkg::ST_PROJECT;
         end
         ppi_pkg::ST_PROJECT: state_in = ppi_pkg::ST_COMBINE;
         ppi_pkg::ST_COMBINE: state_in = ppi_pkg::ST_SCALE;
         ppi_pkg::ST_SCALE:   state_in = ppi_pkg::ST_COMMIT;
         ppi_pkg::ST_COMMIT: begin
            // hold until the result register can take the new pose
            if (!status.out_blocked)
               state_in = ppi_pkg::ST_IDLE;
         end
         default: state_in = ppi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.step   = step_ff;
      req_tready = 1'b0;
      step_in    = '0;
      unique case (state_ff)
         ppi_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ppi_pkg::ST_ROTATE: begin
            cmd.rotate = 1'b1;
            step_in    = last_step ? '0 : step_ff + 1'b1;
         end
         ppi_pkg::ST_PROJECT: cmd.project = 1'b1;
         ppi_pkg::ST_COMBINE: cmd.combine = 1'b1;
         ppi_pkg::ST_SCALE:   cmd.scale   = 1'b1;
         ppi_pkg::ST_COMMIT:  cmd.commit  = !status.out_blocked;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppi_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hw/rtl/planar_pose_integrator.sv =====
// planar dead-reckoning pose integrator, top level
// each accepted word runs the cordic steps, then project, combine, scale and commit
// a new word is taken only once the last one is committed, paced by the iterative cordic,
//   one micro-rotation per cycle; a waiting result does not block the next accept
// reset: synchronous active-high reset clears pose x, y and heading to zero
//   and empties the result register
module planar_pose_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // vel_x, vel_y, turn_rate, time_step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata     // pose_x, pose_y, heading
);

   ppi_pkg::ppi_cmd_type    cmd;
   ppi_pkg::ppi_status_type status;

   ppi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppi_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // a new result appears only from a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result valid without commit");

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_tvalid && !rsp_tready))
      else $error("commit while result register blocked");

   // an accepted word starts the cordic at its first step
   a_accept_starts_cordic: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (cmd.rotate && cmd.step == '0))
      else $error("accept not followed by first cordic step");
`endif

endmodule
